### sv/lcd_decimal_segment_writer_top_defines.svh
`ifndef LCD_DECIMAL_SEGMENT_WRITER_TOP_DEFINES_SVH
`define LCD_DECIMAL_SEGMENT_WRITER_TOP_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define LCDW_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define LCDW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

### sv/lcdw_pkg.sv
`default_nettype none

package lcdw_pkg;

    localparam int POSITIONS   = 6;
    localparam int ROWS        = 4;
    localparam int ROW_STRIDE  = 5;
    localparam int MEM_DEPTH   = ROWS * ROW_STRIDE;
    localparam int MAX_RESULTS = 24;
    localparam int MAX_DIGITS  = MAX_RESULTS / ROWS;
    localparam int ASCII_ZERO  = 48;
    localparam int RECIP_TEN   = 52429;
    localparam int RECIP_SHIFT = 19;

    localparam logic CMD_CHAR   = 1'b0;
    localparam logic CMD_NUMBER = 1'b1;

    typedef struct packed {
        logic        command;
        logic [7:0]  char_code;
        logic [3:0]  position;
        logic [14:0] number;
        logic [2:0]  digit_count;
    } t_in_item;

    typedef struct packed {
        logic [4:0] reg_index;
        logic [7:0] reg_data;
        logic       last_write;
    } t_out_item;

    typedef struct packed {
        logic load;
        logic write;
        logic next_digit;
        logic last;
    } t_ctrl_cmd;

    typedef struct packed {
        logic       has_work;
        logic [2:0] digits;
    } t_dp_status;

    function automatic logic [15:0] digit_pattern(input logic [3:0] digit);
        logic [15:0] pat;
        unique case (digit)
            4'd0:    pat = 16'h1551;
            4'd1:    pat = 16'h0110;
            4'd2:    pat = 16'h1E11;
            4'd3:    pat = 16'h1B11;
            4'd4:    pat = 16'h0B50;
            4'd5:    pat = 16'h1B41;
            4'd6:    pat = 16'h1F41;
            4'd7:    pat = 16'h0111;
            4'd8:    pat = 16'h1F51;
            4'd9:    pat = 16'h1B51;
            default: pat = 16'h0000;
        endcase
        return pat;
    endfunction

endpackage

`default_nettype wire

### sv/lcd_decimal_segment_writer_top.sv
`default_nettype none
`include "lcd_decimal_segment_writer_top_defines.svh"

// Segment LCD decimal digit writer.
// A command transaction is taken at a rising edge where start is high and busy
// is low. A character command merges one digit pattern into four display
// registers; a number command writes its lowest digits from right to left,
// four register writes per digit. Commands that fall outside the display, or
// a number of zero length, are taken but cause no writes.
// Each register write leaves on o_result for exactly one cycle, flagged by
// o_strobe; last_write marks the final write of a command. The first write
// is shown after the command has passed the state register and the result
// register, and the writes then follow one per cycle, set by the single
// read-modify-write port of the display register file; busy stays high
// until the final write is made. A new command may be taken in the cycle in
// which the final write is shown; a command that causes no writes leaves
// busy low. The receiver cannot stall the results.
// Reset clears the display memory to blank and abandons any command in work.
module lcd_decimal_segment_writer_top (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   start,
    output logic                  busy,
    input  lcdw_pkg::t_in_item    i_item,
    output logic                  o_strobe,
    output lcdw_pkg::t_out_item   o_result
);
    import lcdw_pkg::*;

    t_ctrl_cmd  w_cmd;
    t_dp_status w_status;
    logic [1:0] w_row;

    lcdw_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_status (w_status),
        .o_cmd    (w_cmd),
        .o_row    (w_row)
    );

    lcdw_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cmd    (w_cmd),
        .o_status (w_status),
        .o_strobe (o_strobe),
        .o_result (o_result),
        .i_row    (w_row)
    );

    `LCDW_ASSERT_SAME(a_index_range, o_strobe, o_result.reg_index < 5'(MEM_DEPTH), "index out of range")
    `LCDW_ASSERT_NEXT(a_accept_quiet, start && !busy, !o_strobe, "write shown after accept")
    `LCDW_ASSERT_SAME(a_more_pending, o_strobe && !o_result.last_write, busy, "idle with writes due")
    `LCDW_ASSERT_NEXT(a_last_ends, o_strobe && o_result.last_write, !o_strobe, "write after last")

endmodule

`default_nettype wire

### sv/lcdw_datapath.sv
`default_nettype none

module lcdw_datapath (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  lcdw_pkg::t_in_item     i_item,
    input  lcdw_pkg::t_ctrl_cmd    i_cmd,
    output lcdw_pkg::t_dp_status   o_status,
    output logic                   o_strobe,
    output lcdw_pkg::t_out_item    o_result,
    input  wire  [1:0]             i_row
);
    import lcdw_pkg::*;

    logic [7:0]  r_mem [MEM_DEPTH];
    logic [14:0] r_num;
    logic [7:0]  r_code;
    logic        r_is_char;
    logic [3:0]  r_pos;
    logic        r_strobe;
    t_out_item   r_result;

    logic [30:0] w_prod;
    logic [11:0] w_quot;
    logic [14:0] w_rem_full;
    logic [3:0]  w_digit;
    logic [15:0] w_pat;
    logic [3:0]  w_nib;
    logic [4:0]  w_idx;
    logic [7:0]  w_old;
    logic [7:0]  w_new;
    logic [4:0]  w_end;

    assign w_prod     = 31'(r_num) * 31'(RECIP_TEN);
    assign w_quot     = w_prod[30:RECIP_SHIFT];
    assign w_rem_full = r_num - ((15'(w_quot) << 3) + (15'(w_quot) << 1));
    assign w_digit    = w_rem_full[3:0];

    always_comb begin
        if (r_is_char) begin
            if ((r_code >= 8'(ASCII_ZERO)) && (r_code <= 8'(ASCII_ZERO + 9))) begin
                w_pat = digit_pattern(4'(r_code - 8'(ASCII_ZERO)));
            end else begin
                w_pat = 16'h0000;
            end
        end else begin
            w_pat = digit_pattern(w_digit);
        end
    end

    assign w_nib = w_pat[{i_row, 2'b00} +: 4];
    assign w_idx = 5'(({3'b000, i_row} << 2) + {3'b000, i_row}) + 5'(r_pos[3:1]);
    assign w_old = (w_idx < 5'(MEM_DEPTH)) ? r_mem[w_idx] : 8'h00;
    assign w_new = r_pos[0] ? {w_nib, w_old[3:0]} : {w_old[7:4], w_nib};

    assign w_end = {1'b0, i_item.position} + {2'b00, i_item.digit_count};

    always_comb begin
        if (i_item.command == CMD_CHAR) begin
            o_status.has_work = (i_item.position < 4'(POSITIONS));
            o_status.digits   = 3'd1;
        end else begin
            o_status.has_work = (i_item.digit_count != 3'd0) && (w_end <= 5'(POSITIONS));
            o_status.digits   = (i_item.digit_count > 3'(MAX_DIGITS)) ?
                                3'(MAX_DIGITS) : i_item.digit_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_num     <= i_item.number;
            r_code    <= i_item.char_code;
            r_is_char <= (i_item.command == CMD_CHAR);
            if (i_item.command == CMD_CHAR) begin
                r_pos <= i_item.position;
            end else begin
                r_pos <= 4'(w_end - 5'd1);
            end
        end else if (i_cmd.next_digit) begin
            r_num <= 15'(w_quot);
            r_pos <= r_pos - 4'd1;
        end
        if (i_cmd.write) begin
            r_result.reg_index  <= w_idx;
            r_result.reg_data   <= w_new;
            r_result.last_write <= i_cmd.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
            for (int k = 0; k < MEM_DEPTH; k++) begin
                r_mem[k] <= 8'h00;
            end
        end else begin
            r_strobe <= i_cmd.write;
            if (i_cmd.write && (w_idx < 5'(MEM_DEPTH))) begin
                r_mem[w_idx] <= w_new;
            end
        end
    end

    assign o_strobe = r_strobe;
    assign o_result = r_result;

endmodule

`default_nettype wire

### sv/lcdw_ctrl.sv
`default_nettype none

module lcdw_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    start,
    output logic                   busy,
    input  lcdw_pkg::t_dp_status   i_status,
    output lcdw_pkg::t_ctrl_cmd    o_cmd,
    output logic [1:0]             o_row
);
    import lcdw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE  = 2'b01,
        S_WRITE = 2'b10
    } t_state;

    t_state     r_state, n_state;
    logic [1:0] r_row, n_row;
    logic [2:0] r_left, n_left;

    always_comb begin
        n_state          = r_state;
        n_row            = r_row;
        n_left           = r_left;
        o_cmd.load       = 1'b0;
        o_cmd.write      = 1'b0;
        o_cmd.next_digit = 1'b0;
        o_cmd.last       = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (start && i_status.has_work) begin
                    o_cmd.load = 1'b1;
                    n_row      = 2'd0;
                    n_left     = i_status.digits;
                    n_state    = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.write = 1'b1;
                n_row       = r_row + 2'd1;
                if (r_row == 2'(ROWS - 1)) begin
                    o_cmd.next_digit = 1'b1;
                    n_left           = r_left - 3'd1;
                    if (r_left == 3'd1) begin
                        o_cmd.last = 1'b1;
                        n_state    = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= 2'd0;
            r_left  <= 3'd0;
        end else begin
            r_state <= n_state;
            r_row   <= n_row;
            r_left  <= n_left;
        end
    end

    assign busy  = (r_state != S_IDLE);
    assign o_row = r_row;

endmodule

`default_nettype wire

### dv/lcd_decimal_segment_writer_top_tb.sv
`timescale 1ns / 1ps

module lcd_decimal_segment_writer_top_tb;
    import lcdw_pkg::*;

    typedef struct {
        t_in_item cmd;
        bit       drain;
        int       idle_pct;
    } t_pending_cmd;

    // Segment patterns for the digits nine down to zero, digit zero in the low 16 bits.
    localparam logic [159:0] SEGMENT_FONT = {
        16'h1B51, 16'h1F51, 16'h0111, 16'h1F41, 16'h1B41,
        16'h0B50, 16'h1B11, 16'h1E11, 16'h0110, 16'h1551
    };

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      start = 1'b0;
    t_in_item  i_item = '0;
    logic      busy;
    logic      o_strobe;
    t_out_item o_result;

    t_pending_cmd pending_q[$];
    t_out_item    expected_writes_q[$];
    t_out_item    glyph_writes[$];
    logic [7:0]   lcd_ram [MEM_DEPTH];
    int           writes_predicted = 0;
    int           writes_seen = 0;
    int           error_count = 0;

    lcd_decimal_segment_writer_top i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_item   (i_item),
        .o_strobe (o_strobe),
        .o_result (o_result)
    );

    always #5 i_clk = ~i_clk;

    task automatic merge_glyph(input int code, input int pos);
        logic [15:0] glyph;
        logic [3:0]  nib;
        int          idx;
        t_out_item   wr;
        glyph = 16'h0000;
        if (pos >= POSITIONS) return;
        if (code >= ASCII_ZERO && code <= ASCII_ZERO + 9)
            glyph = SEGMENT_FONT[(code - ASCII_ZERO) * 16 +: 16];
        for (int row = 0; row < ROWS; row++) begin
            if (glyph_writes.size() >= MAX_RESULTS) return;
            idx = row * ROW_STRIDE + pos / 2;
            nib = glyph[row * 4 +: 4];
            if (pos % 2 == 0) begin
                lcd_ram[idx] = {lcd_ram[idx][7:4], nib};
            end else begin
                lcd_ram[idx] = {nib, lcd_ram[idx][3:0]};
            end
            wr.reg_index  = idx[4:0];
            wr.reg_data   = lcd_ram[idx];
            wr.last_write = 1'b0;
            glyph_writes.push_back(wr);
        end
    endtask

    task automatic predict_writes(input t_in_item cmd);
        int        value;
        int        len;
        t_out_item wr;
        glyph_writes.delete();
        if (cmd.command == CMD_CHAR) begin
            merge_glyph(int'(cmd.char_code), int'(cmd.position));
        end else if (int'(cmd.position) + int'(cmd.digit_count) <= POSITIONS) begin
            value = int'(cmd.number);
            len = int'(cmd.digit_count);
            for (int i = 0; i < len; i++) begin
                merge_glyph(ASCII_ZERO + value % 10, int'(cmd.position) + len - 1 - i);
                value = value / 10;
            end
        end
        if (glyph_writes.size() > 0) begin
            wr = glyph_writes[glyph_writes.size() - 1];
            wr.last_write = 1'b1;
            glyph_writes[glyph_writes.size() - 1] = wr;
        end
        foreach (glyph_writes[k]) expected_writes_q.push_back(glyph_writes[k]);
        writes_predicted += glyph_writes.size();
    endtask

    always @(posedge i_clk) begin : drive_proc
        bit           slot_free;
        t_pending_cmd nxt;
        if (i_rst_n) begin
            if (o_strobe) writes_seen++;
            if (start && !busy) predict_writes(i_item);
            slot_free = !start || !busy;
            if (slot_free) begin
                if (pending_q.size() == 0) begin
                    start <= 1'b0;
                end else begin
                    nxt = pending_q[0];
                    if ((nxt.drain && writes_predicted != writes_seen) ||
                        $urandom_range(99) < nxt.idle_pct) begin
                        start <= 1'b0;
                    end else begin
                        start  <= 1'b1;
                        i_item <= nxt.cmd;
                        pending_q.delete(0);
                    end
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_proc
        t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (expected_writes_q.size() == 0) begin
                $error("unexpected register write: reg_index %0d, reg_data 0x%02h",
                       o_result.reg_index, o_result.reg_data);
                error_count++;
            end else begin
                want = expected_writes_q.pop_front();
                if (o_result.reg_index !== want.reg_index) begin
                    $error("reg_index: expected %0d, actual %0d",
                           want.reg_index, o_result.reg_index);
                    error_count++;
                end
                if (o_result.reg_data !== want.reg_data) begin
                    $error("reg_data: expected 0x%02h, actual 0x%02h",
                           want.reg_data, o_result.reg_data);
                    error_count++;
                end
                if (o_result.last_write !== want.last_write) begin
                    $error("last_write: expected %0b, actual %0b",
                           want.last_write, o_result.last_write);
                    error_count++;
                end
            end
        end
    end

    function automatic t_in_item make_cmd(input logic cmd_kind, input int code, input int pos,
                                          input int num, input int len);
        t_in_item c;
        c.command     = cmd_kind;
        c.char_code   = code[7:0];
        c.position    = pos[3:0];
        c.number      = num[14:0];
        c.digit_count = len[2:0];
        return c;
    endfunction

    function automatic t_in_item random_cmd();
        t_in_item c;
        int       len;
        c = make_cmd(CMD_CHAR, $urandom, $urandom, $urandom, $urandom);
        if ($urandom_range(99) < 15) begin
            c.command = 1'($urandom_range(1));
        end else if ($urandom_range(1) == 0) begin
            c.command = CMD_CHAR;
            if ($urandom_range(9) != 0)
                c.char_code = 8'($urandom_range(ASCII_ZERO + 9, ASCII_ZERO));
            c.position = 4'($urandom_range(POSITIONS - 1));
        end else begin
            c.command = CMD_NUMBER;
            len = $urandom_range(POSITIONS, 1);
            c.digit_count = 3'(len);
            c.position = 4'($urandom_range(POSITIONS - len));
            if ($urandom_range(3) == 0) c.number = 15'($urandom_range(999));
        end
        return c;
    endfunction

    task automatic queue_cmd(input t_in_item cmd, input bit drain, input int idle_pct);
        t_pending_cmd p;
        p.cmd = cmd;
        p.drain = drain;
        p.idle_pct = idle_pct;
        pending_q.push_back(p);
    endtask

    initial begin
        int phase_idle [4];
        phase_idle[0] = 0;
        phase_idle[1] = 79;
        phase_idle[2] = 0;
        phase_idle[3] = 10;
        foreach (lcd_ram[k]) lcd_ram[k] = 8'h00;

        queue_cmd(make_cmd(CMD_CHAR, ASCII_ZERO, 0, 0, 0), 1'b0, 0);
        queue_cmd(make_cmd(CMD_CHAR, ASCII_ZERO + 9, 5, 32767, 7), 1'b0, 0);
        queue_cmd(make_cmd(CMD_CHAR, ASCII_ZERO + 8, 1, 0, 0), 1'b0, 0);
        queue_cmd(make_cmd(CMD_CHAR, 0, 2, 0, 0), 1'b0, 0);
        queue_cmd(make_cmd(CMD_CHAR, 255, 3, 0, 0), 1'b0, 0);
        queue_cmd(make_cmd(CMD_CHAR, ASCII_ZERO - 1, 4, 0, 0), 1'b0, 0);
        queue_cmd(make_cmd(CMD_CHAR, ASCII_ZERO + 10, 0, 0, 0), 1'b0, 0);
        queue_cmd(make_cmd(CMD_CHAR, ASCII_ZERO + 5, 6, 0, 0), 1'b0, 0);
        queue_cmd(make_cmd(CMD_CHAR, ASCII_ZERO + 1, 15, 0, 0), 1'b0, 0);
        queue_cmd(make_cmd(CMD_NUMBER, 0, 0, 0, 6), 1'b0, 0);
        queue_cmd(make_cmd(CMD_NUMBER, 255, 1, 32767, 5), 1'b0, 0);
        queue_cmd(make_cmd(CMD_NUMBER, ASCII_ZERO, 0, 12345, 6), 1'b0, 0);
        queue_cmd(make_cmd(CMD_NUMBER, 0, 0, 32767, 7), 1'b0, 0);
        queue_cmd(make_cmd(CMD_NUMBER, 0, 2, 5, 0), 1'b0, 0);
        queue_cmd(make_cmd(CMD_NUMBER, 0, 4, 99, 3), 1'b0, 0);
        queue_cmd(make_cmd(CMD_NUMBER, 0, 5, 7, 1), 1'b0, 0);
        queue_cmd(make_cmd(CMD_NUMBER, 0, 15, 42, 2), 1'b0, 0);
        queue_cmd(make_cmd(CMD_NUMBER, 0, 0, 9, 1), 1'b0, 0);
        queue_cmd(make_cmd(CMD_CHAR, ASCII_ZERO + 4, 0, 0, 0), 1'b0, 0);
        queue_cmd(make_cmd(CMD_CHAR, ASCII_ZERO + 7, 3, 0, 0), 1'b0, 0);
        queue_cmd(make_cmd(CMD_CHAR, ASCII_ZERO + 2, 4, 0, 0), 1'b0, 0);
        queue_cmd(make_cmd(CMD_CHAR, ASCII_ZERO + 3, 5, 0, 0), 1'b0, 0);
        queue_cmd(make_cmd(CMD_CHAR, ASCII_ZERO + 6, 2, 0, 0), 1'b0, 0);

        for (int phase = 0; phase < 4; phase++) begin
            for (int n = 0; n < 78; n++) begin
                queue_cmd(random_cmd(), (n % 40 == 0), phase_idle[phase]);
            end
        end

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (pending_q.size() != 0 || start) @(posedge i_clk);
        while (expected_writes_q.size() != 0) @(posedge i_clk);
        repeat (30) @(posedge i_clk);
        if (error_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial begin
        #2000000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### files.f
+incdir+sv
sv/lcdw_pkg.sv
sv/lcdw_datapath.sv
sv/lcdw_ctrl.sv
sv/lcd_decimal_segment_writer_top.sv
dv/lcd_decimal_segment_writer_top_tb.sv
